>>> design/absplit_pkg.sv
// shared constants and controller/datapath interface types for the range splitter
`default_nettype none
package absplit_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int MAX_RESULTS = 64;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 33;
    localparam int ORD_W  = 6;
    localparam int POW_W  = SIZE_W + 1;
    localparam int SUM_W  = SIZE_W + 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS);

    localparam int IN_DATA_W  = ((ADDR_W + SIZE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + ORD_W + 7) / 8) * 8;

    localparam logic [SUM_W-1:0]  ADDR_TOP  = SUM_W'(1) << ADDR_BITS;
    localparam logic [ADDR_W-1:0] PAGE_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
    localparam logic [POW_W-1:0]  POW_INIT  = POW_W'(1) << PAGE_SHIFT;
    localparam logic [SIZE_W-1:0] MASK_INIT = (SIZE_W'(1) << PAGE_SHIFT) - SIZE_W'(1);
    localparam logic [ORD_W-1:0]  ORD_INIT  = ORD_W'(PAGE_SHIFT);

    typedef struct packed {
        logic load;
        logic step_down;
        logic step_up;
        logic emit;
        logic emit_err;
        logic cap_last;
    } t_cmd;

    typedef struct packed {
        logic size_zero;
        logic range_bad;
        logic pow_gt_size;
        logic up_ok;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> design/absplit_dp.sv
// datapath: cursor, remaining size, block order ladder and output register
`default_nettype none
module absplit_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire absplit_pkg::t_cmd                 i_cmd,
    output absplit_pkg::t_sts                      o_sts,
    input  wire logic [absplit_pkg::ADDR_W-1:0]    i_start_addr,
    input  wire logic [absplit_pkg::SIZE_W-1:0]    i_range_size,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [absplit_pkg::ADDR_W-1:0]         o_block_base,
    output logic [absplit_pkg::ORD_W-1:0]          o_block_order,
    output logic                                   o_range_error,
    output logic                                   o_last_block
);
    import absplit_pkg::*;

    logic [SIZE_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [POW_W-1:0]  r_pow;
    logic [SIZE_W-1:0] r_mask;
    logic [ORD_W-1:0]  r_order;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_base;
    logic [ORD_W-1:0]  r_out_order;
    logic              r_out_err;
    logic              r_out_last;

    logic [SIZE_W-1:0] w_blk;
    logic [SUM_W-1:0]  w_end;
    logic              w_rem_zero;

    assign w_blk      = r_pow[POW_W-1:1];
    assign w_end      = SUM_W'(r_addr[ADDR_W-1:0]) + SUM_W'(r_size);
    assign w_rem_zero = (r_size == w_blk);

    assign o_sts.size_zero   = (r_size == '0);
    assign o_sts.range_bad   = ((r_addr[ADDR_W-1:0] & PAGE_MASK) != '0) || (w_end > ADDR_TOP);
    assign o_sts.pow_gt_size = (r_pow > POW_W'(r_size));
    assign o_sts.up_ok       = (r_pow <= POW_W'(r_size)) && ((r_addr & r_mask) == '0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= SIZE_W'(i_start_addr);
            r_size  <= i_range_size;
            r_pow   <= POW_INIT;
            r_mask  <= MASK_INIT;
            r_order <= ORD_INIT;
        end else if (i_cmd.step_up) begin
            r_pow   <= {r_pow[POW_W-2:0], 1'b0};
            r_mask  <= {r_mask[SIZE_W-2:0], 1'b1};
            r_order <= r_order + ORD_W'(1);
        end else if (i_cmd.step_down || i_cmd.emit) begin
            r_pow   <= r_pow >> 1;
            r_mask  <= r_mask >> 1;
            r_order <= r_order - ORD_W'(1);
        end
        if (i_cmd.emit) begin
            r_addr <= r_addr + w_blk;
            r_size <= r_size - w_blk;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_base  <= r_addr[ADDR_W-1:0];
            r_out_order <= r_order - ORD_W'(1);
            r_out_err   <= 1'b0;
            r_out_last  <= w_rem_zero || i_cmd.cap_last;
        end else if (i_cmd.emit_err) begin
            r_out_base  <= r_addr[ADDR_W-1:0];
            r_out_order <= '0;
            r_out_err   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_base  = r_out_base;
    assign o_block_order = r_out_order;
    assign o_range_error = r_out_err;
    assign o_last_block  = r_out_last;

    ap_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_err) |=> r_out_valid)
        else $error("output word not registered after emit");

    ap_emit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (w_blk <= r_size))
        else $error("emitted block larger than remaining size");

    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(i_cmd.emit || i_cmd.emit_err))
        else $error("pending output word overwritten");

endmodule
`default_nettype wire

>>> design/absplit_ctrl.sv
// controller: range check, order ladder stepping and block emission sequencing
`default_nettype none
module absplit_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire absplit_pkg::t_sts i_sts,
    output absplit_pkg::t_cmd      o_cmd
);
    import absplit_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DOWN  = 3'd2;
    localparam logic [2:0] S_UP    = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_cap;

    assign w_cap      = (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.cap_last = w_cap;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_sts.size_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.range_bad) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DOWN;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DOWN: begin
                if (i_sts.pow_gt_size) begin
                    o_cmd.step_down = 1'b1;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (i_sts.up_ok) begin
                    o_cmd.step_up = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_cnt      = r_cnt + CNT_W'(1);
                    // remaining size exhausted shows up as size_zero next cycle
                    n_state    = w_cap ? S_IDLE : S_DOWN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a block that empties the range ends the run
        if (r_state == S_DOWN && i_sts.size_zero) begin
            o_cmd.step_down = 1'b0;
            n_state         = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    ap_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.emit_err) |-> i_sts.out_free)
        else $error("emit while output register busy");

    ap_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit && o_cmd.emit_err))
        else $error("block and error emitted together");

    ap_cap_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && w_cap) |=> (r_state == S_IDLE))
        else $error("emission continued past result cap");

endmodule
`default_nettype wire

>>> design/aligned_block_range_splitter_top.sv
// top level of the aligned block range splitter
//
// slave channel takes one range word: start address and size in bytes.
// master channel gives one word per naturally aligned power-of-two block,
// low to high address, with tlast on the final block of the range.
// tuser flags an error word: start not page aligned or range past the top
// address; such a range gives exactly one word (base = start, order 0).
// a zero size gives no word. at most 64 blocks per range, the 64th with tlast.
// one range is in flight at a time; tready on the slave side is high only
// while the controller is idle, and the last output word may still be
// waiting when the next range is taken.
// sequence: a range is first taken and then checked; then per block the
// order steps down, the search turns from downward to upward, the order
// steps up and the block is emitted, all on the single order register that
// walks one step per cycle; after the final block the controller sees the
// range empty, or the 64th block reaches the cap, and frees the slave side.
// a range at 0x1000 of 4 GiB less 8 KiB climbs from page order to 30 and
// back in 38 blocks.
// a stalled master side holds the output register and the block waits.
// synchronous active-low reset returns the controller to idle and drops tvalid.
`default_nettype none
module aligned_block_range_splitter_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // [31:0] start_addr, [64:32] range_size, rest zero
    input  wire logic [absplit_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] block_base, [37:32] block_order, rest zero
    output logic [absplit_pkg::OUT_DATA_W-1:0]       m_tdata,
    // [0] range_error
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready
);
    import absplit_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [ADDR_W-1:0] w_base;
    logic [ORD_W-1:0]  w_order;

    absplit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    absplit_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_start_addr  (s_tdata[ADDR_W-1:0]),
        .i_range_size  (s_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
        .i_out_ready   (m_tready),
        .o_out_valid   (m_tvalid),
        .o_block_base  (w_base),
        .o_block_order (w_order),
        .o_range_error (m_tuser),
        .o_last_block  (m_tlast)
    );

    assign m_tdata = {(OUT_DATA_W - ADDR_W - ORD_W)'(0), w_order, w_base};

endmodule
`default_nettype wire

>>> bench/aligned_block_range_splitter_top_tb.sv
// testbench for the aligned block range splitter: directed and random ranges, checked per block
`timescale 1ns / 1ps
module aligned_block_range_splitter_top_tb;
    import absplit_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [33:0] SPACE_TOP = 34'd1 << ADDR_BITS;

    typedef struct {
        logic [31:0] base;
        logic [5:0]  order;
        logic        err;
        logic        last;
    } block_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    block_t      pending_blocks[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    logic [31:0] split_cursor = '0;
    logic [32:0] split_left = '0;
    logic [5:0]  split_order = ORD_W'(PAGE_SHIFT);

    aligned_block_range_splitter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // works out the blocks of one range and queues them
    function automatic void split_range(input logic [31:0] start, input logic [32:0] size);
        logic [33:0] cur;
        logic [33:0] left;
        int          ord;
        int          n;
        block_t      b;
        if (size == 0) begin
            split_cursor = start;
            split_left   = '0;
            split_order  = ORD_W'(PAGE_SHIFT);
            return;
        end
        if ((start & PAGE_MASK) != 0 || {2'b0, start} > SPACE_TOP
                || {1'b0, size} > SPACE_TOP - {2'b0, start}) begin
            b.base  = start;
            b.order = '0;
            b.err   = 1'b1;
            b.last  = 1'b1;
            pending_blocks.push_back(b);
            return;
        end
        cur  = {2'b0, start};
        left = {1'b0, size};
        ord  = PAGE_SHIFT;
        n    = 0;
        while (left > 0 && n < MAX_RESULTS) begin
            while ((34'd1 << ord) > left)
                ord--;
            while ((34'd1 << ord) <= left && (cur & ((34'd1 << ord) - 34'd1)) == 0)
                ord++;
            ord--;
            left    = left - (34'd1 << ord);
            b.base  = cur[31:0];
            b.order = ORD_W'(ord);
            b.err   = 1'b0;
            b.last  = (left == 0 || n == MAX_RESULTS - 1);
            pending_blocks.push_back(b);
            cur = cur + (34'd1 << ord);
            n++;
        end
        split_cursor = cur[31:0];
        split_left   = left[32:0];
        split_order  = ORD_W'(ord);
    endfunction

    task automatic send_range(input logic [31:0] start, input logic [32:0] size);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tdata  <= IN_DATA_W'({size, start});
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        split_range(start, size);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver with random stall bursts while idle_on is set, always ready otherwise
    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        block_t exp_b;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected word base %h order %0d err %b last %b", $time,
                         m_tdata[31:0], m_tdata[37:32], m_tuser, m_tlast);
                mismatches++;
            end else begin
                exp_b = pending_blocks.pop_front();
                if (m_tdata[31:0] !== exp_b.base || m_tdata[37:32] !== exp_b.order
                        || m_tuser !== exp_b.err || m_tlast !== exp_b.last) begin
                    $display("%0t: expected base %h order %0d err %b last %b, got base %h order %0d err %b last %b",
                             $time, exp_b.base, exp_b.order, exp_b.err, exp_b.last,
                             m_tdata[31:0], m_tdata[37:32], m_tuser, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_zero_size();
        send_range(32'h0000_5000, 33'd0);
        send_range(32'hFFFF_F000, 33'd0);
        send_range(32'h0000_0123, 33'd0);
    endtask

    task automatic test_rejected_ranges();
        send_range(32'h0000_0001, 33'h0_0000_1000);
        send_range(32'hFFFF_FFFF, 33'd1);
        send_range(32'h0000_0800, 33'h1_FFFF_FFFF);
        send_range(32'hFFFF_F000, 33'h0_0000_2000);
        send_range(32'h0000_1000, 33'h1_0000_0000);
        send_range(32'hFFFF_F000, 33'h1_FFFF_FFFF);
    endtask

    task automatic test_aligned_splits();
        send_range(32'h0000_0000, 33'h1_0000_0000);
        send_range(32'hFFFF_F000, 33'h0_0000_1000);
        send_range(32'h0000_1000, 33'd1);
        send_range(32'h0000_1000, 33'h0_FFFF_F000);
        send_range(32'h0000_1000, 33'h0_FFFF_EFFF);
        send_range(32'h0000_3000, 33'h0_0000_1235);
        send_range(32'h8000_0000, 33'h0_8000_0000);
        send_range(32'h0000_0000, 33'h0_0000_1FFF);
        send_range(32'h0000_5000, 33'h0_0000_5000);
    endtask

    task automatic test_drain_pause();
        send_range(32'h0000_7000, 33'h0_0123_4567);
        wait_drained();
        send_range(32'h0001_0000, 33'h0_0001_0000);
        wait_drained();
    endtask

    task automatic send_random_range();
        logic [31:0] start;
        logic [63:0] room;
        logic [63:0] size;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            start = $urandom;
            send_range(start, 33'd0);
        end else if (pick < 5) begin
            start = $urandom;
            if (start[11:0] == 0)
                start[$urandom_range(0, 11)] = 1'b1;
            send_range(start, 33'($urandom_range(0, 1) ? {$urandom_range(0, 1), $urandom}
                                                       : $urandom_range(1, 65536)));
        end else if (pick < 7) begin
            start = {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
            send_range(start, 33'({$urandom_range(0, 1), $urandom}));
        end else begin
            start = {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
            if ($urandom_range(0, 7) == 0)
                start = '0;
            room = 64'(SPACE_TOP) - 64'(start);
            case ($urandom_range(0, 3))
                0: size = 64'($urandom_range(1, 16384));
                1: size = 64'($urandom_range(1, 64)) << PAGE_SHIFT;
                2: size = ({32'($urandom), 32'($urandom)} % room) + 64'd1;
                default: size = room;
            endcase
            if (size > room)
                size = room;
            send_range(start, size[32:0]);
        end
    endtask

    task automatic test_random_ranges(input int count);
        repeat (count) send_random_range();
    endtask

    task automatic test_random_no_idle(input int count);
        idle_on = 1'b0;
        repeat (count) send_random_range();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_size();
        test_rejected_ranges();
        test_aligned_splits();
        test_drain_pause();
        test_random_ranges(120);
        test_random_no_idle(30);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/absplit_pkg.sv
design/absplit_dp.sv
design/absplit_ctrl.sv
design/aligned_block_range_splitter_top.sv
bench/aligned_block_range_splitter_top_tb.sv
